// File: sv/stb_pkg.sv
package stb_pkg;

  // number of timers built, 1 to 4
  localparam int NUM_TIMERS = 4;

  localparam int CNT_W  = 16;
  localparam int IDX_W  = 2;
  localparam int MASK_W = 4;

  typedef enum logic [2:0] {
    CMD_TICK       = 3'd0,
    CMD_START      = 3'd1,
    CMD_START_KEEP = 3'd2,
    CMD_STOP       = 3'd3,
    CMD_POLL       = 3'd4
  } stb_cmd_t;

  typedef enum logic [1:0] {
    MODE_OFF      = 2'd0,
    MODE_ONESHOT  = 2'd1,
    MODE_PERIODIC = 2'd2,
    MODE_RESERVED = 2'd3
  } stb_mode_t;

  // one word as seen by every timer slot
  typedef struct packed {
    logic             step;
    stb_cmd_t         cmd;
    stb_mode_t        mode;
    logic [CNT_W-1:0] interval;
  } stb_ctrl_t;

  // status of one slot
  typedef struct packed {
    logic flag;
    logic flag_next;
    logic fire;
  } stb_slot_t;

endpackage

// File: sv/soft_timer_bank.sv
// bank of NUM_TIMERS 16-bit down-counting timers, each off, oneshot, periodic or
// reserved (idle). a tick word steps every timer; start, start-keeping-count,
// stop and poll words address one timer by index and words with an unknown
// command change nothing. every input word gives exactly one output word
// carrying the polled flag (zero unless poll), the mask of timers that fired
// (zero unless tick) and all flags after the step. the bank takes one word per
// clock when the output side keeps up: a word is held in the input register,
// the timer slots apply it in parallel and the result lands in the output
// register. all flags read set after reset.
module soft_timer_bank
  import stb_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // slave side
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // timer_index[1:0], mode[3:2], interval[19:4], zero pad
  input  logic [2:0]  s_tuser,   // cmd[2:0]
  // master side
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata    // poll_flag[0], fired_mask[4:1], flag_vector[8:5], zero pad
);

  // input register
  logic             in_valid;
  stb_cmd_t         in_cmd;
  logic [IDX_W-1:0] in_index;
  stb_mode_t        in_mode;
  logic [CNT_W-1:0] in_interval;

  // output register
  logic              out_valid;
  logic              out_poll;
  logic [MASK_W-1:0] out_fired;
  logic [MASK_W-1:0] out_flags;

  logic advance;

  // the input word moves on whenever the output register is free or drains
  assign advance  = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_cmd      <= stb_cmd_t'(s_tuser);
      in_index    <= s_tdata[1:0];
      in_mode     <= stb_mode_t'(s_tdata[3:2]);
      in_interval <= s_tdata[19:4];
    end
  end

  // timer slots, state changes only when the word advances
  stb_ctrl_t ctrl;
  stb_slot_t slot [NUM_TIMERS];
  logic      sel  [NUM_TIMERS];

  assign ctrl.step     = advance;
  assign ctrl.cmd      = in_cmd;
  assign ctrl.mode     = in_mode;
  assign ctrl.interval = in_interval;

  for (genvar i = 0; i < NUM_TIMERS; i++) begin : g_timer
    // an index at or above NUM_TIMERS selects no slot
    assign sel[i] = (in_index == IDX_W'(i));

    stb_timer u_timer (
      .clk    (clk),
      .rst    (rst),
      .ctrl   (ctrl),
      .sel    (sel[i]),
      .status (slot[i])
    );
  end

  // gather the result
  logic              res_poll;
  logic [MASK_W-1:0] res_fired;
  logic [MASK_W-1:0] res_flags;

  always_comb begin
    res_poll  = 1'b0;
    res_fired = '0;
    res_flags = '0;
    for (int i = 0; i < NUM_TIMERS; i++) begin
      if (in_cmd == CMD_POLL && sel[i]) begin
        res_poll = slot[i].flag;
      end
      res_fired[i] = slot[i].fire;
      res_flags[i] = slot[i].flag_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_poll  <= res_poll;
      out_fired <= res_fired;
      out_flags <= res_flags;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {7'd0, out_flags, out_fired, out_poll};

endmodule

// File: sv/stb_timer.sv
module stb_timer
  import stb_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  stb_ctrl_t ctrl,
  input  logic      sel,
  output stb_slot_t status
);

  logic [CNT_W-1:0] count, count_next;
  logic [CNT_W-1:0] reload_value, reload_value_next;
  stb_mode_t        timer_mode, timer_mode_next;
  logic             done_flag, done_flag_next;
  logic             fire;

  always_comb begin
    count_next        = count;
    reload_value_next = reload_value;
    timer_mode_next   = timer_mode;
    done_flag_next    = done_flag;
    fire              = 1'b0;
    if (ctrl.step) begin
      case (ctrl.cmd)
        CMD_TICK: begin
          if (timer_mode == MODE_ONESHOT && !done_flag) begin
            if (count == '0) begin
              done_flag_next = 1'b1;
              fire           = 1'b1;
            end else begin
              count_next = count - CNT_W'(1);
            end
          end else if (timer_mode == MODE_PERIODIC) begin
            if (count == '0) begin
              done_flag_next = 1'b1;
              fire           = 1'b1;
              count_next     = reload_value;
            end else begin
              count_next = count - CNT_W'(1);
            end
          end
        end
        CMD_START, CMD_START_KEEP: begin
          if (sel) begin
            reload_value_next = ctrl.interval;
            // keep-count variant reloads the count only for a oneshot
            if (ctrl.cmd == CMD_START || ctrl.mode == MODE_ONESHOT) begin
              count_next = ctrl.interval;
            end
            done_flag_next  = 1'b0;
            timer_mode_next = ctrl.mode;
          end
        end
        CMD_STOP: begin
          if (sel) begin
            timer_mode_next = MODE_OFF;
          end
        end
        CMD_POLL: begin
          if (sel) begin
            done_flag_next = 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count        <= '0;
      reload_value <= '0;
      timer_mode   <= MODE_OFF;
      done_flag    <= 1'b1;
    end else begin
      count        <= count_next;
      reload_value <= reload_value_next;
      timer_mode   <= timer_mode_next;
      done_flag    <= done_flag_next;
    end
  end

  assign status.flag      = done_flag;
  assign status.flag_next = done_flag_next;
  assign status.fire      = fire;

endmodule

// File: sim/stb_checker.sv
`timescale 1ns / 1ps

module stb_checker
  import stb_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [23:0] s_tdata,   // timer_index[1:0], mode[3:2], interval[19:4], zero pad
  input  logic [2:0]  s_tuser,   // cmd[2:0]
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [15:0] m_tdata,   // poll_flag[0], fired_mask[4:1], flag_vector[8:5], zero pad
  output int          fail_count,
  output int          pending
);

  typedef struct packed {
    logic [6:0]        pad;
    logic [MASK_W-1:0] flags;
    logic [MASK_W-1:0] fired;
    logic              polled;
  } timer_result_t;

  // own copy of the timer bank
  logic [CNT_W-1:0] count_r  [MASK_W];
  logic [CNT_W-1:0] reload_r [MASK_W];
  stb_mode_t        mode_r   [MASK_W];
  logic             flag_r   [MASK_W];

  timer_result_t result_q[$];

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  task automatic report(input string what, input int got, input int want);
    $display("%0t: %s mismatch, got %0h, expected %0h", $time, what, got, want);
    fail_count++;
  endtask

  task automatic step_bank(input logic [2:0] op, input logic [IDX_W-1:0] idx,
                           input stb_mode_t md, input logic [CNT_W-1:0] ival,
                           output timer_result_t res);
    logic hit;
    res = '0;
    hit = int'(idx) < NUM_TIMERS;
    case (op)
      CMD_TICK: begin
        for (int t = 0; t < NUM_TIMERS; t++) begin
          case (mode_r[t])
            MODE_ONESHOT: begin
              // a fired oneshot holds until restarted or polled
              if (!flag_r[t]) begin
                if (count_r[t] == 0) begin
                  flag_r[t]    = 1'b1;
                  res.fired[t] = 1'b1;
                end else begin
                  count_r[t] = count_r[t] - 1'b1;
                end
              end
            end
            MODE_PERIODIC: begin
              if (count_r[t] == 0) begin
                flag_r[t]    = 1'b1;
                res.fired[t] = 1'b1;
                count_r[t]   = reload_r[t];
              end else begin
                count_r[t] = count_r[t] - 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      CMD_START, CMD_START_KEEP: begin
        if (hit) begin
          reload_r[idx] = ival;
          if (op == CMD_START || md == MODE_ONESHOT) count_r[idx] = ival;
          flag_r[idx] = 1'b0;
          mode_r[idx] = md;
        end
      end
      CMD_STOP: begin
        if (hit) mode_r[idx] = MODE_OFF;
      end
      CMD_POLL: begin
        if (hit) begin
          res.polled  = flag_r[idx];
          flag_r[idx] = 1'b0;
        end
      end
      default: ;
    endcase
    for (int t = 0; t < NUM_TIMERS; t++) res.flags[t] = flag_r[t];
  endtask

  always @(posedge clk) begin
    timer_result_t want;
    timer_result_t got;
    if (rst) begin
      for (int t = 0; t < MASK_W; t++) begin
        count_r[t]  = '0;
        reload_r[t] = '0;
        mode_r[t]   = MODE_OFF;
        flag_r[t]   = 1'b1;
      end
      result_q.delete();
    end else begin
      // input side first, so a result that came out in the same cycle as its word would still find its entry
      if (s_tvalid && s_tready) begin
        step_bank(s_tuser, s_tdata[1:0], stb_mode_t'(s_tdata[3:2]), s_tdata[19:4], want);
        result_q.push_back(want);
      end
      if (m_tvalid && m_tready) begin
        got = timer_result_t'(m_tdata);
        if (result_q.size() == 0) begin
          report("unexpected word", m_tdata, 0);
        end else begin
          want = result_q.pop_front();
          if (got.polled !== want.polled) report("poll flag", got.polled, want.polled);
          if (got.fired !== want.fired)   report("fired mask", got.fired, want.fired);
          if (got.flags !== want.flags)   report("flag vector", got.flags, want.flags);
          if (got.pad !== want.pad)       report("padding", got.pad, want.pad);
        end
      end
    end
    pending = result_q.size();
  end

endmodule

// File: sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import stb_pkg::*;

  // command codes beyond the defined set, which the bank must ignore
  localparam logic [2:0] CMD_SPARE_LO = 3'd5;
  localparam logic [2:0] CMD_SPARE_HI = 3'd7;

  localparam int RANDOM_WORDS = 1400;
  localparam int LIMIT_CYCLES = 200000;
  localparam int DRAIN_CYCLES = 10;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [23:0] s_tdata;    // timer_index[1:0], mode[3:2], interval[19:4], zero pad
  logic [2:0]  s_tuser;    // cmd[2:0]
  logic        m_tvalid;
  logic        m_tready;
  logic [15:0] m_tdata;    // poll_flag[0], fired_mask[4:1], flag_vector[8:5], zero pad

  int   fail_count;
  int   pending;
  // set during a long window where neither side idles
  logic quiet;

  soft_timer_bank uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // watches both channels, predicts every result word and compares
  stb_checker timer_check (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // output side stalls at random, about 29 percent of the time, never in the quiet window
  always @(negedge clk) begin
    m_tready <= quiet ? 1'b1 : ($urandom_range(0, 99) >= 29);
  end

  // hard stop in case the bank hangs
  initial begin
    repeat (LIMIT_CYCLES) @(posedge clk);
    $display("[FAIL] regression broken");
    $finish;
  end

  // present one word at the falling edge, with random idle gaps ahead of it,
  // and hold it until the bank takes it
  task automatic send_word(input logic [2:0] op, input logic [IDX_W-1:0] idx,
                           input stb_mode_t md, input logic [CNT_W-1:0] ival);
    while (!quiet && $urandom_range(0, 99) < 29) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {4'b0, ival, md, idx};
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  // mostly short intervals so timers actually reach zero, now and then any value
  function automatic logic [CNT_W-1:0] pick_interval();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 70) return CNT_W'($urandom_range(0, 7));
    if (roll < 90) return CNT_W'($urandom_range(0, 40));
    return CNT_W'($urandom_range(0, 65535));
  endfunction

  initial begin
    int              roll;
    int              pick;
    logic [2:0]      op;
    logic [IDX_W-1:0] idx;
    stb_mode_t       md;

    rst      = 1'b1;
    quiet    = 1'b0;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    s_tuser  = '0;
    m_tready = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed part: flags all set after reset, so polls read one
    send_word(CMD_POLL, 2'd0, MODE_OFF, 16'h0000);
    send_word(CMD_POLL, 2'd3, MODE_RESERVED, 16'hffff);
    // tick with every timer off changes nothing
    send_word(CMD_TICK, 2'd0, MODE_OFF, 16'h0000);
    // oneshot at zero fires on the first tick, then holds
    send_word(CMD_START, 2'd0, MODE_ONESHOT, 16'h0000);
    send_word(CMD_TICK, 2'd0, MODE_OFF, 16'h0000);
    send_word(CMD_TICK, 2'd0, MODE_OFF, 16'h0000);
    // polling a oneshot that sits at zero lets it fire again
    send_word(CMD_POLL, 2'd0, MODE_OFF, 16'h0000);
    send_word(CMD_TICK, 2'd0, MODE_OFF, 16'h0000);
    // periodic with interval zero fires on every tick
    send_word(CMD_START, 2'd1, MODE_PERIODIC, 16'h0000);
    send_word(CMD_TICK, 2'd0, MODE_OFF, 16'h0000);
    send_word(CMD_TICK, 2'd0, MODE_OFF, 16'h0000);
    // largest interval, then start-keep on a periodic keeps the count
    send_word(CMD_START, 2'd2, MODE_PERIODIC, 16'hffff);
    send_word(CMD_START_KEEP, 2'd2, MODE_PERIODIC, 16'h0003);
    // start-keep on a oneshot does load the count
    send_word(CMD_START_KEEP, 2'd3, MODE_ONESHOT, 16'h0001);
    send_word(CMD_TICK, 2'd0, MODE_OFF, 16'h0000);
    send_word(CMD_TICK, 2'd0, MODE_OFF, 16'h0000);
    send_word(CMD_TICK, 2'd0, MODE_OFF, 16'h0000);
    // reserved mode sits idle, stop keeps flag and count
    send_word(CMD_START, 2'd3, MODE_RESERVED, 16'haaaa);
    send_word(CMD_STOP, 2'd1, MODE_PERIODIC, 16'h5555);
    send_word(CMD_TICK, 2'd0, MODE_OFF, 16'h0000);
    // unknown commands only report the flag vector
    send_word(CMD_SPARE_LO, 2'd2, MODE_ONESHOT, 16'h1234);
    send_word(CMD_SPARE_HI, 2'd1, MODE_PERIODIC, 16'hfedc);
    send_word(CMD_START, 2'd0, MODE_OFF, 16'hffff);
    send_word(CMD_POLL, 2'd1, MODE_OFF, 16'h0000);
    send_word(CMD_START_KEEP, 2'd1, MODE_PERIODIC, 16'h0000);

    // random part: tick-heavy mix so started timers run down and fire,
    // with polls, stops, restarts and unknown commands mixed in
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      quiet = (n >= 500 && n < 800);
      roll  = $urandom_range(0, 99);
      idx   = IDX_W'($urandom_range(0, 3));
      pick  = $urandom_range(0, 9);
      md    = (pick == 0) ? MODE_OFF :
              (pick < 5)  ? MODE_ONESHOT :
              (pick < 9)  ? MODE_PERIODIC : MODE_RESERVED;
      if (roll < 45)      op = CMD_TICK;
      else if (roll < 60) op = CMD_START;
      else if (roll < 70) op = CMD_START_KEEP;
      else if (roll < 77) op = CMD_STOP;
      else if (roll < 95) op = CMD_POLL;
      else                op = 3'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI));
      send_word(op, idx, md, pick_interval());
    end
    quiet    = 1'b0;
    s_tvalid <= 1'b0;

    // let every outstanding result come back, then a few more cycles
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
